// ----- rtl/shm_pkg.sv -----
// Shared widths, reset values, record codes and control bundles of the sample histogram.
package shm_pkg;

  // Fixed field widths of the ports.
  localparam int SmpW   = 32;
  localparam int BinW   = 6;
  localparam int TallyW = 13;
  localparam int VarW   = 40;
  localparam int DevW   = 32;

  // Default sizes handed to the top level.
  localparam int MaxSamplesDef = 4096;
  localparam int MaxBarsDef    = 63;

  // Reset value of the bin count register.
  localparam logic [BinW-1:0] BinsRst = 6'd32;

  // Set state reset values.
  localparam logic [SmpW-1:0] MinRst = 32'h7FFF_FFFF;
  localparam logic [SmpW-1:0] MaxRst = 32'h8000_0000;

  // Record kinds.
  localparam logic KindBar  = 1'b0;
  localparam logic KindStat = 1'b1;

  // Control of the sample store.
  typedef struct packed {
    logic wr;
    logic rd;
  } store_ctl_t;

  // Control of the bin count memory.
  typedef struct packed {
    logic rd;
    logic wr;
    logic clr;
  } tally_ctl_t;

endpackage

// ----- rtl/sample_histogram_with_moments.sv -----
// Top level of the auto-ranged sample histogram with weighted mean, variance and deviation.
//
//  Channel   Handshake                     Payload
//  --------  ----------------------------  ------------------------------------------------
//  input     start_i & !busy_o             sample_i, last_sample_i
//  result    result_valid_o (one cycle)    item_kind_o, bar_index_o, bar_center_o, bar_tally_o,
//                                          mean_value_o, variance_value_o, deviation_value_o,
//                                          last_result_o
//  config    cfg_valid_i & cfg_ready_o     cfg_data_i (bins_in_use)
//
// Samples load at one per cycle into the sample store while busy_o is low.
// The last sample closes the set; busy_o then stays high while the per-sample binning pass,
// the per-bin record and moment passes, the serial divider (one quotient bit a cycle)
// and the square root run; DW, the divider width, is 64 plus the count width (77 by default).
// Bin records go out first, the statistics record last; results cannot stall.
// Reset clears the set state and the bin counts at once; no clearing pass is needed.
module sample_histogram_with_moments #(
  parameter int MaxSamples = shm_pkg::MaxSamplesDef,
  parameter int MaxBars    = shm_pkg::MaxBarsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [shm_pkg::SmpW-1:0] sample_i,
  input  logic                          last_sample_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [shm_pkg::BinW-1:0]      cfg_data_i,
  output logic                          result_valid_o,
  output logic                          item_kind_o,
  output logic [shm_pkg::BinW-1:0]      bar_index_o,
  output logic signed [shm_pkg::SmpW-1:0] bar_center_o,
  output logic [shm_pkg::TallyW-1:0]    bar_tally_o,
  output logic signed [shm_pkg::SmpW-1:0] mean_value_o,
  output logic [shm_pkg::VarW-1:0]      variance_value_o,
  output logic [shm_pkg::DevW-1:0]      deviation_value_o,
  output logic                          last_result_o
);

  localparam int CW  = $clog2(MaxSamples + 1);
  localparam int AW  = $clog2(MaxSamples);
  localparam int IW  = $clog2(MaxBars);
  localparam int DW  = 64 + CW;
  localparam int RW  = (CW + 16 > 33) ? CW + 16 : 33;
  localparam int SW  = $clog2(DW + 1);
  localparam int WSW = CW + 33;

  typedef enum logic [18:0] {
    ST_LOAD = 19'h00001,
    ST_STEP = 19'h00002,
    ST_BRD  = 19'h00004,
    ST_BMUL = 19'h00008,
    ST_BDIV = 19'h00010,
    ST_BINC = 19'h00020,
    ST_BWR  = 19'h00040,
    ST_ERD  = 19'h00080,
    ST_EOUT = 19'h00100,
    ST_EACC = 19'h00200,
    ST_MEAN = 19'h00400,
    ST_VRD  = 19'h00800,
    ST_VSQ  = 19'h01000,
    ST_VMUL = 19'h02000,
    ST_VACC = 19'h04000,
    ST_VAR  = 19'h08000,
    ST_DEV  = 19'h10000,
    ST_SQRT = 19'h20000,
    ST_STAT = 19'h40000
  } state_e;

  // Control registers.
  state_e                   state_q, state_d;
  logic                     run_q, run_d;
  logic [shm_pkg::BinW-1:0] bins_q, bins_d;
  logic [shm_pkg::BinW-1:0] nb_q, nb_d;
  logic [CW-1:0]            total_q, total_d;
  logic [shm_pkg::SmpW-1:0] mn_q, mn_d;
  logic [shm_pkg::SmpW-1:0] mx_q, mx_d;
  logic [CW-1:0]            k_q, k_d;
  logic [IW-1:0]            i_q, i_d;
  logic                     res_valid_q, res_valid_d;

  // Datapath registers.
  logic [32:0]              qstep_q, qstep_d;
  logic [6:0]               rstep_q, rstep_d;
  logic [32:0]              cq_q, cq_d;
  logic [7:0]               cr_q, cr_d;
  logic [38:0]              num_q, num_d;
  logic [IW-1:0]            j_q, j_d;
  logic signed [WSW-1:0]    prod_q, prod_d;
  logic signed [WSW-1:0]    wsum_q, wsum_d;
  logic [shm_pkg::SmpW-1:0] mean_q, mean_d;
  logic [65:0]              sq_q, sq_d;
  logic [CW-1:0]            cnt_q, cnt_d;
  logic [33+CW:0]           pa_q, pa_d;
  logic [31+CW:0]           pb_q, pb_d;
  logic [DW-1:0]            acc_q, acc_d;
  logic [shm_pkg::VarW-1:0] var_q, var_d;
  logic [63:0]              v_q, v_d;

  // Result registers.
  logic                       kind_q, kind_d;
  logic [shm_pkg::BinW-1:0]   idx_q, idx_d;
  logic [shm_pkg::SmpW-1:0]   cen_q, cen_d;
  logic [shm_pkg::TallyW-1:0] tal_q, tal_d;
  logic [shm_pkg::SmpW-1:0]   omean_q, omean_d;
  logic [shm_pkg::VarW-1:0]   ovar_q, ovar_d;
  logic [shm_pkg::DevW-1:0]   odev_q, odev_d;
  logic                       olast_q, olast_d;

  // Unit connections.
  shm_pkg::store_ctl_t      st_ctl;
  shm_pkg::tally_ctl_t      ta_ctl;
  logic [AW-1:0]            st_rd_addr;
  logic [shm_pkg::SmpW-1:0] st_rd_data;
  logic [IW-1:0]            ta_rd_addr;
  logic [CW-1:0]            ta_rd_data;
  logic [CW-1:0]            ta_wr_data;
  logic                     div_start;
  logic [DW-1:0]            div_num;
  logic [RW-1:0]            div_rem_in;
  logic [RW-1:0]            div_den;
  logic [SW-1:0]            div_steps;
  logic                     div_done;
  logic [DW-1:0]            div_quot;
  logic [RW-1:0]            div_rem;
  logic                     sq_start;
  logic                     sq_done;
  logic [31:0]              sq_root;
  logic [33:0]              sq_rem;

  // Shared combinational terms.
  logic                     in_xfer;
  logic                     room;
  logic [shm_pkg::BinW-1:0] nbm1;
  logic [CW-1:0]            n_w;
  logic [32:0]              rng_w;
  logic [33:0]              cen_full;
  logic [shm_pkg::SmpW-1:0] cen_w;
  logic [7:0]               rsum;
  logic [7:0]               dstep;
  logic [32:0]              sdiff;
  logic [40:0]              bd;
  logic [6:0]               jr;
  logic [6:0]               jc;
  logic [WSW-1:0]           mag_w;
  logic [33:0]              dv;
  logic [33:0]              adv;
  logic [CW+15:0]           nsh;
  logic                     rup;
  logic [DW:0]              vr;
  logic [32:0]              dev_r;
  logic [shm_pkg::DevW-1:0] dev_w;

  assign busy_o      = (state_q != ST_LOAD);
  assign cfg_ready_o = 1'b1;
  assign in_xfer     = start_i && !busy_o;
  assign room        = (total_q < CW'(MaxSamples));
  assign nbm1        = nb_q - 1'b1;
  assign n_w         = (total_q == '0) ? CW'(1) : total_q;

  // Value range of the set; empty-range guard for an inverted pair.
  always_comb begin
    rng_w = {mx_q[31], mx_q} - {mn_q[31], mn_q};
    if ($signed(mx_q) < $signed(mn_q)) begin
      rng_w = '0;
    end
  end

  // Bin centre generator: running quotient and remainder of (2*i*range + bins-1)/(2*(bins-1)).
  assign cen_full = {{2{mn_q[31]}}, mn_q} + {1'b0, cq_q};
  assign cen_w    = cen_full[31:0];
  assign dstep    = {1'b0, nbm1, 1'b0};
  assign rsum     = cr_q + {1'b0, rstep_q};

  // Bin position terms.
  assign sdiff = {st_rd_data[31], st_rd_data} - {mn_q[31], mn_q};
  assign bd    = 41'({num_q, 1'b0}) + 41'(rng_w);
  assign jr    = div_quot[6:0];
  assign jc    = (jr > {1'b0, nbm1}) ? {1'b0, nbm1} : jr;

  // Moment terms.
  assign mag_w = wsum_q[WSW-1] ? WSW'(-wsum_q) : WSW'(wsum_q);
  assign dv    = {{2{cen_w[31]}}, cen_w} - {{2{mean_q[31]}}, mean_q};
  assign adv   = dv[33] ? -dv : dv;
  assign nsh   = {n_w, 16'h0000};
  assign rup   = ({div_rem, 1'b0} >= {1'b0, RW'(nsh)});
  assign vr    = {1'b0, div_quot} + {{DW{1'b0}}, rup};
  assign dev_r = (sq_rem > {2'b00, sq_root}) ? {1'b0, sq_root} + 33'd1 : {1'b0, sq_root};
  assign dev_w = dev_r[32] ? '1 : dev_r[31:0];

  // Divider operand selection.
  always_comb begin
    div_num    = '0;
    div_rem_in = '0;
    div_den    = '0;
    div_steps  = SW'(DW);
    case (state_q)
      ST_STEP: begin
        div_num = DW'({rng_w, 1'b0});
        div_den = RW'(dstep);
      end
      ST_BDIV: begin
        div_num    = {bd[6:0], {(DW-7){1'b0}}};
        div_rem_in = RW'(bd[40:7]);
        div_den    = RW'({rng_w, 1'b0});
        div_steps  = SW'(7);
      end
      ST_MEAN: begin
        div_num = DW'({mag_w, 1'b0}) + DW'(n_w);
        div_den = RW'({n_w, 1'b0});
      end
      ST_VAR: begin
        div_num = acc_q;
        div_den = RW'(nsh);
      end
      ST_DEV: begin
        div_num = acc_q;
        div_den = RW'(n_w);
      end
      default: begin
        div_num = '0;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    run_d       = run_q;
    bins_d      = bins_q;
    nb_d        = nb_q;
    total_d     = total_q;
    mn_d        = mn_q;
    mx_d        = mx_q;
    k_d         = k_q;
    i_d         = i_q;
    res_valid_d = 1'b0;
    qstep_d     = qstep_q;
    rstep_d     = rstep_q;
    cq_d        = cq_q;
    cr_d        = cr_q;
    num_d       = num_q;
    j_d         = j_q;
    prod_d      = prod_q;
    wsum_d      = wsum_q;
    mean_d      = mean_q;
    sq_d        = sq_q;
    cnt_d       = cnt_q;
    pa_d        = pa_q;
    pb_d        = pb_q;
    acc_d       = acc_q;
    var_d       = var_q;
    v_d         = v_q;
    kind_d      = kind_q;
    idx_d       = idx_q;
    cen_d       = cen_q;
    tal_d       = tal_q;
    omean_d     = omean_q;
    ovar_d      = ovar_q;
    odev_d      = odev_q;
    olast_d     = olast_q;
    st_ctl      = '0;
    ta_ctl      = '0;
    st_rd_addr  = k_q[AW-1:0];
    ta_rd_addr  = i_q;
    ta_wr_data  = ta_rd_data + 1'b1;
    div_start   = 1'b0;
    sq_start    = 1'b0;

    if (cfg_valid_i) begin
      bins_d = cfg_data_i;
    end

    case (state_q)
      // Load samples and track the extremes.
      ST_LOAD: begin
        if (in_xfer) begin
          if (room) begin
            st_ctl.wr = 1'b1;
            total_d   = total_q + 1'b1;
            if (sample_i < $signed(mn_q)) begin
              mn_d = sample_i;
            end
            if (sample_i > $signed(mx_q)) begin
              mx_d = sample_i;
            end
          end
          if (last_sample_i) begin
            if (bins_q < shm_pkg::BinW'(2)) begin
              nb_d = shm_pkg::BinW'(2);
            end else if (bins_q > shm_pkg::BinW'(MaxBars)) begin
              nb_d = shm_pkg::BinW'(MaxBars);
            end else begin
              nb_d = bins_q;
            end
            state_d = ST_STEP;
          end
        end
      end
      // Centre spacing: quotient and remainder of 2*range/(2*(bins-1)).
      ST_STEP: begin
        if (!run_q) begin
          div_start = 1'b1;
          run_d     = 1'b1;
        end else if (div_done) begin
          run_d   = 1'b0;
          qstep_d = div_quot[32:0];
          rstep_d = div_rem[6:0];
          k_d     = '0;
          state_d = ST_BRD;
        end
      end
      // Binning pass over the stored samples.
      ST_BRD: begin
        if (k_q == total_q) begin
          cq_d    = '0;
          cr_d    = {2'b00, nbm1};
          i_d     = '0;
          wsum_d  = '0;
          state_d = ST_ERD;
        end else begin
          st_ctl.rd = 1'b1;
          state_d   = ST_BMUL;
        end
      end
      ST_BMUL: begin
        num_d   = sdiff * nbm1;
        state_d = ST_BDIV;
      end
      ST_BDIV: begin
        if (rng_w == '0) begin
          j_d     = (mn_q == '0) ? '0 : IW'(nb_q >> 1);
          state_d = ST_BINC;
        end else if (!run_q) begin
          div_start = 1'b1;
          run_d     = 1'b1;
        end else if (div_done) begin
          run_d   = 1'b0;
          j_d     = IW'(jc);
          state_d = ST_BINC;
        end
      end
      ST_BINC: begin
        ta_ctl.rd  = 1'b1;
        ta_rd_addr = j_q;
        state_d    = ST_BWR;
      end
      ST_BWR: begin
        ta_ctl.wr = 1'b1;
        k_d       = k_q + 1'b1;
        state_d   = ST_BRD;
      end
      // Bin records and the weighted sum.
      ST_ERD: begin
        ta_ctl.rd = 1'b1;
        state_d   = ST_EOUT;
      end
      ST_EOUT: begin
        res_valid_d = 1'b1;
        kind_d      = shm_pkg::KindBar;
        idx_d       = shm_pkg::BinW'(i_q);
        cen_d       = cen_w;
        tal_d       = shm_pkg::TallyW'(ta_rd_data);
        omean_d     = '0;
        ovar_d      = '0;
        odev_d      = '0;
        olast_d     = 1'b0;
        prod_d      = $signed({1'b0, ta_rd_data}) * $signed(cen_w);
        state_d     = ST_EACC;
      end
      ST_EACC: begin
        wsum_d = wsum_q + prod_q;
        if (rsum >= dstep) begin
          cr_d = rsum - dstep;
          cq_d = cq_q + qstep_q + 33'd1;
        end else begin
          cr_d = rsum;
          cq_d = cq_q + qstep_q;
        end
        if (i_q == IW'(nbm1)) begin
          state_d = ST_MEAN;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = ST_ERD;
        end
      end
      // Weighted mean, rounded half away from zero.
      ST_MEAN: begin
        if (!run_q) begin
          div_start = 1'b1;
          run_d     = 1'b1;
        end else if (div_done) begin
          run_d   = 1'b0;
          mean_d  = wsum_q[WSW-1] ? -div_quot[31:0] : div_quot[31:0];
          cq_d    = '0;
          cr_d    = {2'b00, nbm1};
          i_d     = '0;
          acc_d   = '0;
          state_d = ST_VRD;
        end
      end
      // Second moment pass.
      ST_VRD: begin
        ta_ctl.rd = 1'b1;
        state_d   = ST_VSQ;
      end
      ST_VSQ: begin
        sq_d    = adv[32:0] * adv[32:0];
        cnt_d   = ta_rd_data;
        state_d = ST_VMUL;
      end
      ST_VMUL: begin
        pa_d    = sq_q[65:32] * cnt_q;
        pb_d    = sq_q[31:0] * cnt_q;
        state_d = ST_VACC;
      end
      ST_VACC: begin
        acc_d = acc_q + DW'({pa_q, 32'h0000_0000}) + DW'(pb_q);
        if (rsum >= dstep) begin
          cr_d = rsum - dstep;
          cq_d = cq_q + qstep_q + 33'd1;
        end else begin
          cr_d = rsum;
          cq_d = cq_q + qstep_q;
        end
        if (i_q == IW'(nbm1)) begin
          state_d = ST_VAR;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = ST_VRD;
        end
      end
      // Variance in Q24.16, rounded and saturated.
      ST_VAR: begin
        if (!run_q) begin
          div_start = 1'b1;
          run_d     = 1'b1;
        end else if (div_done) begin
          run_d   = 1'b0;
          var_d   = (|vr[DW:shm_pkg::VarW]) ? '1 : vr[shm_pkg::VarW-1:0];
          state_d = ST_DEV;
        end
      end
      // Mean square in raw units for the root.
      ST_DEV: begin
        if (!run_q) begin
          div_start = 1'b1;
          run_d     = 1'b1;
        end else if (div_done) begin
          run_d   = 1'b0;
          v_d     = div_quot[63:0];
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (!run_q) begin
          sq_start = 1'b1;
          run_d    = 1'b1;
        end else if (sq_done) begin
          run_d   = 1'b0;
          odev_d  = dev_w;
          state_d = ST_STAT;
        end
      end
      // Statistics record, then the set is cleared.
      ST_STAT: begin
        res_valid_d = 1'b1;
        kind_d      = shm_pkg::KindStat;
        idx_d       = '0;
        cen_d       = '0;
        tal_d       = shm_pkg::TallyW'(total_q);
        omean_d     = mean_q;
        ovar_d      = var_q;
        olast_d     = 1'b1;
        total_d     = '0;
        mn_d        = shm_pkg::MinRst;
        mx_d        = shm_pkg::MaxRst;
        ta_ctl.clr  = 1'b1;
        state_d     = ST_LOAD;
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      run_q       <= 1'b0;
      bins_q      <= shm_pkg::BinsRst;
      nb_q        <= shm_pkg::BinsRst;
      total_q     <= '0;
      mn_q        <= shm_pkg::MinRst;
      mx_q        <= shm_pkg::MaxRst;
      k_q         <= '0;
      i_q         <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      run_q       <= run_d;
      bins_q      <= bins_d;
      nb_q        <= nb_d;
      total_q     <= total_d;
      mn_q        <= mn_d;
      mx_q        <= mx_d;
      k_q         <= k_d;
      i_q         <= i_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Datapath and result payload.
  always_ff @(posedge clk_i) begin
    qstep_q <= qstep_d;
    rstep_q <= rstep_d;
    cq_q    <= cq_d;
    cr_q    <= cr_d;
    num_q   <= num_d;
    j_q     <= j_d;
    prod_q  <= prod_d;
    wsum_q  <= wsum_d;
    mean_q  <= mean_d;
    sq_q    <= sq_d;
    cnt_q   <= cnt_d;
    pa_q    <= pa_d;
    pb_q    <= pb_d;
    acc_q   <= acc_d;
    var_q   <= var_d;
    v_q     <= v_d;
    kind_q  <= kind_d;
    idx_q   <= idx_d;
    cen_q   <= cen_d;
    tal_q   <= tal_d;
    omean_q <= omean_d;
    ovar_q  <= ovar_d;
    odev_q  <= odev_d;
    olast_q <= olast_d;
  end

  shm_store #(
    .Depth (MaxSamples),
    .AW    (AW)
  ) u_store (
    .clk_i     (clk_i),
    .ctl_i     (st_ctl),
    .wr_addr_i (total_q[AW-1:0]),
    .wr_data_i (sample_i),
    .rd_addr_i (st_rd_addr),
    .rd_data_o (st_rd_data)
  );

  shm_tally #(
    .Bars (MaxBars),
    .IW   (IW),
    .CW   (CW)
  ) u_tally (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ta_ctl),
    .rd_addr_i (ta_rd_addr),
    .wr_addr_i (j_q),
    .wr_data_i (ta_wr_data),
    .rd_data_o (ta_rd_data)
  );

  shm_div #(
    .DW (DW),
    .RW (RW),
    .SW (SW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .rem_i   (div_rem_in),
    .den_i   (div_den),
    .steps_i (div_steps),
    .done_o  (div_done),
    .quot_o  (div_quot),
    .rem_o   (div_rem)
  );

  shm_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .val_i   (v_q),
    .done_o  (sq_done),
    .root_o  (sq_root),
    .rem_o   (sq_rem)
  );

  assign result_valid_o    = res_valid_q;
  assign item_kind_o       = kind_q;
  assign bar_index_o       = idx_q;
  assign bar_center_o      = cen_q;
  assign bar_tally_o       = tal_q;
  assign mean_value_o      = omean_q;
  assign variance_value_o  = ovar_q;
  assign deviation_value_o = odev_q;
  assign last_result_o     = olast_q;

  // The statistics record leaves with the block already idle again.
  a_stat_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_result_o) |-> !busy_o)
    else $error("statistics record while still busy");

  // No bin record goes out while samples are being loaded.
  a_no_result_in_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_result_o) |-> busy_o)
    else $error("bin record while loading");

  // The sample count never passes the store depth.
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CW'(MaxSamples))
    else $error("sample count beyond store depth");

  // The binning pass never runs past the stored samples.
  a_pass_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BMUL) |-> (k_q < total_q))
    else $error("binning read beyond the set");

endmodule

// ----- rtl/shm_store.sv -----
// Sample store: single-port-write, registered-read memory for one set of samples.
module shm_store #(
  parameter int Depth = shm_pkg::MaxSamplesDef,
  parameter int AW    = $clog2(Depth)
) (
  input  logic                      clk_i,
  input  shm_pkg::store_ctl_t       ctl_i,
  input  logic [AW-1:0]             wr_addr_i,
  input  logic [shm_pkg::SmpW-1:0]  wr_data_i,
  input  logic [AW-1:0]             rd_addr_i,
  output logic [shm_pkg::SmpW-1:0]  rd_data_o
);

  logic [shm_pkg::SmpW-1:0] mem_q [Depth];
  logic [shm_pkg::SmpW-1:0] rd_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

// ----- rtl/shm_tally.sv -----
// Bin count memory with per-entry valid bits so that a cleared entry reads as zero.
module shm_tally #(
  parameter int Bars = shm_pkg::MaxBarsDef,
  parameter int IW   = $clog2(Bars),
  parameter int CW   = 13
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  shm_pkg::tally_ctl_t ctl_i,
  input  logic [IW-1:0]       rd_addr_i,
  input  logic [IW-1:0]       wr_addr_i,
  input  logic [CW-1:0]       wr_data_i,
  output logic [CW-1:0]       rd_data_o
);

  logic [CW-1:0]   mem_q [Bars];
  logic [Bars-1:0] vld_q;
  logic [CW-1:0]   rd_q;
  logic            rd_vld_q;

  // Count storage and registered read.
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.rd) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  // Valid bits: set on a write, all dropped when a set closes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (ctl_i.clr) begin
        vld_q <= '0;
      end else if (ctl_i.wr) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (ctl_i.rd) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

  // The sequencer never reads and writes the same entry in one cycle.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.rd && ctl_i.wr) |-> (rd_addr_i != wr_addr_i))
    else $error("tally read and write collide");

  // A write never coincides with the clearing of the valid bits.
  a_no_wr_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.clr |-> !ctl_i.wr)
    else $error("tally write during clear");

  // After a clear every entry reads as zero.
  a_clr_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.clr |=> (vld_q == '0))
    else $error("valid bits survive a clear");

endmodule

// ----- rtl/shm_div.sv -----
// Serial restoring divider: one quotient bit per cycle from a preloaded partial remainder.
module shm_div #(
  parameter int DW = 77,
  parameter int RW = 33,
  parameter int SW = $clog2(DW + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] num_i,
  input  logic [RW-1:0] rem_i,
  input  logic [RW-1:0] den_i,
  input  logic [SW-1:0] steps_i,
  output logic          done_o,
  output logic [DW-1:0] quot_o,
  output logic [RW-1:0] rem_o
);

  logic          busy_q;
  logic [SW-1:0] cnt_q;
  logic          done_q;
  logic [DW-1:0] num_q;
  logic [DW-1:0] quot_q;
  logic [RW-1:0] rem_q;
  logic [RW-1:0] den_q;
  logic [RW:0]   trial;
  logic          ge;
  logic [RW:0]   diff;

  // One trial subtraction per cycle.
  assign trial = {rem_q, num_q[DW-1]};
  assign ge    = (trial >= {1'b0, den_q});
  assign diff  = trial - {1'b0, den_q};

  // Control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= steps_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == SW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= num_i;
      rem_q  <= rem_i;
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      num_q  <= {num_q[DW-2:0], 1'b0};
      rem_q  <= ge ? diff[RW-1:0] : trial[RW-1:0];
      quot_q <= {quot_q[DW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider restarted while busy");

  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> (den_i != '0))
    else $error("divide by zero");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (rem_q < den_q))
    else $error("partial remainder out of range");

endmodule

// ----- rtl/shm_sqrt.sv -----
// Serial integer square root of a 64-bit value, two radicand bits per cycle.
module shm_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] val_i,
  output logic        done_o,
  output logic [31:0] root_o,
  output logic [33:0] rem_o
);

  logic        busy_q;
  logic [5:0]  cnt_q;
  logic        done_q;
  logic [63:0] val_q;
  logic [33:0] rem_q;
  logic [31:0] root_q;
  logic [35:0] trial;
  logic [35:0] tq;
  logic        ge;
  logic [35:0] diff;

  // Trial subtraction of 4*root+1 against the next radicand pair.
  assign trial = {rem_q, val_q[63:62]};
  assign tq    = {2'b00, root_q, 2'b01};
  assign ge    = (trial >= tq);
  assign diff  = trial - tq;

  // Control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd32;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q  <= val_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      val_q  <= {val_q[61:0], 2'b00};
      rem_q  <= ge ? diff[33:0] : trial[33:0];
      root_q <= {root_q[30:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;
  assign rem_o  = rem_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("square root restarted while busy");

  // The remainder of an integer root never exceeds twice the root.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (rem_q <= {1'b0, root_q, 1'b0}))
    else $error("square root remainder out of range");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("square root done held");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench of the auto-ranged sample histogram with weighted moments.
`timescale 1ns / 1ps

module tb_top;

  localparam int MaxSamples = shm_pkg::MaxSamplesDef;
  localparam int MaxBars    = shm_pkg::MaxBarsDef;
  localparam int StallLimit = 300000;

  // One bin or statistics record as it leaves the block.
  typedef struct {
    logic                       kind;
    logic [shm_pkg::BinW-1:0]   index;
    logic [shm_pkg::SmpW-1:0]   center;
    logic [shm_pkg::TallyW-1:0] tally;
    logic [shm_pkg::SmpW-1:0]   mean;
    logic [shm_pkg::VarW-1:0]   variance;
    logic [shm_pkg::DevW-1:0]   deviation;
    logic                       last_flag;
  } hist_rec_t;

  typedef struct {
    logic [shm_pkg::SmpW-1:0] value;
    logic                     last;
  } sample_item_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            start_i;
  logic                            busy_o;
  logic signed [shm_pkg::SmpW-1:0] sample_i;
  logic                            last_sample_i;
  logic                            cfg_valid_i;
  logic                            cfg_ready_o;
  logic [shm_pkg::BinW-1:0]        cfg_data_i;
  logic                            result_valid_o;
  logic                            item_kind_o;
  logic [shm_pkg::BinW-1:0]        bar_index_o;
  logic signed [shm_pkg::SmpW-1:0] bar_center_o;
  logic [shm_pkg::TallyW-1:0]      bar_tally_o;
  logic signed [shm_pkg::SmpW-1:0] mean_value_o;
  logic [shm_pkg::VarW-1:0]        variance_value_o;
  logic [shm_pkg::DevW-1:0]        deviation_value_o;
  logic                            last_result_o;

  sample_item_t pending_samples[$];
  hist_rec_t    expected_records[$];
  int           send_idle_pct;
  bit           failed;
  int           quiet_cycles;

  // Predictor state: the current set and the bin count register.
  longint    set_samples[$];
  longint    set_min;
  longint    set_max;
  logic [shm_pkg::BinW-1:0] bins_reg;

  sample_histogram_with_moments dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .sample_i, .last_sample_i,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i, .result_valid_o, .item_kind_o,
    .bar_index_o, .bar_center_o, .bar_tally_o, .mean_value_o, .variance_value_o,
    .deviation_value_o, .last_result_o
  );

  // Clock and reset.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Integer square root, rounded down.
  function automatic bit [63:0] floor_sqrt(bit [63:0] v);
    bit [63:0] res;
    bit [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic void clear_set_state();
    set_samples.delete();
    set_min = 64'sd2147483647;
    set_max = -64'sd2147483648;
  endfunction

  // Takes one accepted sample; on the last one builds the histogram and moments.
  function automatic void absorb_sample(logic [shm_pkg::SmpW-1:0] raw, logic last);
    longint    x;
    longint    nb, n, nn, mn, mx, span, j, num, wsum, mag, mean, d;
    longint    centre[MaxBars];
    longint    cnt[MaxBars];
    bit [127:0] acc, t, dn, q128;
    bit [63:0] ad, v, dev;
    hist_rec_t r;
    x = longint'(signed'(raw));
    if (set_samples.size() < MaxSamples) begin
      set_samples.push_back(x);
      if (x < set_min) set_min = x;
      if (x > set_max) set_max = x;
    end
    if (!last) return;
    nb = bins_reg;
    if (nb < 2) nb = 2;
    if (nb > MaxBars) nb = MaxBars;
    n  = set_samples.size();
    mn = set_min;
    mx = (set_max < set_min) ? set_min : set_max;
    span = mx - mn;
    for (int i = 0; i < nb; i++) begin
      centre[i] = mn + (2 * i * span + nb - 1) / (2 * (nb - 1));
      cnt[i] = 0;
    end
    foreach (set_samples[k]) begin
      if (span == 0) begin
        j = (mn == 0) ? 0 : nb / 2;
      end else begin
        num = (set_samples[k] - mn) * (nb - 1);
        j = (2 * num + span) / (2 * span);
      end
      if (j > nb - 1) j = nb - 1;
      cnt[j]++;
    end
    wsum = 0;
    for (int i = 0; i < nb; i++) begin
      r = '{shm_pkg::KindBar, shm_pkg::BinW'(i), centre[i][31:0],
            shm_pkg::TallyW'(cnt[i]), '0, '0, '0, 1'b0};
      expected_records.push_back(r);
      wsum += cnt[i] * centre[i];
    end
    nn = (n == 0) ? 1 : n;
    mag = (wsum < 0) ? -wsum : wsum;
    mag = (2 * mag + nn) / (2 * nn);
    mean = (wsum < 0) ? -mag : mag;
    // Exact weighted sum of squared distances from the rounded mean.
    acc = 0;
    for (int i = 0; i < nb; i++) begin
      d = centre[i] - mean;
      ad = (d < 0) ? -d : d;
      t = ad;
      t = t * t * cnt[i];
      acc += t;
    end
    dn = nn << 16;
    q128 = (2 * acc + dn) / (2 * dn);
    if (q128 > 128'hFF_FFFF_FFFF) q128 = 128'hFF_FFFF_FFFF;
    v = 64'(acc / nn);
    dev = floor_sqrt(v);
    if (v - dev * dev > dev) dev++;
    if (dev > 64'hFFFF_FFFF) dev = 64'hFFFF_FFFF;
    r = '{shm_pkg::KindStat, '0, '0, shm_pkg::TallyW'(n), mean[31:0],
          q128[shm_pkg::VarW-1:0], dev[shm_pkg::DevW-1:0], 1'b1};
    expected_records.push_back(r);
    clear_set_state();
  endfunction

  // Driver: presents queued samples, idling at random between transfers.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i       <= 1'b0;
      sample_i      <= '0;
      last_sample_i <= 1'b0;
    end else if (!start_i || !busy_o) begin
      if (start_i) absorb_sample(sample_i, last_sample_i);
      if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        start_i       <= 1'b1;
        sample_i      <= pending_samples[0].value;
        last_sample_i <= pending_samples[0].last;
        void'(pending_samples.pop_front());
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Monitor: every result strobe is compared with the oldest expected record.
  always @(posedge clk_i) begin
    hist_rec_t e;
    if (rst_ni && result_valid_o) begin
      if (expected_records.size() == 0) begin
        $error("unexpected record kind=%0d index=%0d", item_kind_o, bar_index_o);
        failed = 1'b1;
      end else begin
        e = expected_records.pop_front();
        if (item_kind_o !== e.kind) begin
          $error("item_kind exp %0d got %0d", e.kind, item_kind_o); failed = 1'b1;
        end
        if (bar_index_o !== e.index) begin
          $error("bar_index exp %0d got %0d", e.index, bar_index_o); failed = 1'b1;
        end
        if (bar_center_o !== e.center) begin
          $error("bar_center exp %h got %h", e.center, bar_center_o); failed = 1'b1;
        end
        if (bar_tally_o !== e.tally) begin
          $error("bar_tally exp %0d got %0d", e.tally, bar_tally_o); failed = 1'b1;
        end
        if (mean_value_o !== e.mean) begin
          $error("mean_value exp %h got %h", e.mean, mean_value_o); failed = 1'b1;
        end
        if (variance_value_o !== e.variance) begin
          $error("variance_value exp %h got %h", e.variance, variance_value_o); failed = 1'b1;
        end
        if (deviation_value_o !== e.deviation) begin
          $error("deviation_value exp %h got %h", e.deviation, deviation_value_o);
          failed = 1'b1;
        end
        if (last_result_o !== e.last_flag) begin
          $error("last_result exp %0d got %0d", e.last_flag, last_result_o); failed = 1'b1;
        end
      end
    end
  end

  // Watchdog over cycles without any transfer.
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("[sample_histogram_with_moments] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_sample(logic [shm_pkg::SmpW-1:0] value, logic last);
    sample_item_t s;
    s.value = value;
    s.last  = last;
    pending_samples.push_back(s);
  endtask

  // Waits until the block has drained, then writes the bin count register.
  task automatic write_bins(logic [shm_pkg::BinW-1:0] value);
    while (pending_samples.size() > 0 || start_i || expected_records.size() > 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    bins_reg = value;
    cfg_valid_i <= 1'b0;
  endtask

  // A random set: full-range, narrow-range or constant content.
  task automatic queue_random_set(int len);
    int flavour;
    logic [shm_pkg::SmpW-1:0] base;
    logic [shm_pkg::SmpW-1:0] val;
    flavour = $urandom_range(9);
    base = $urandom;
    for (int i = 0; i < len; i++) begin
      if (flavour < 5)      val = $urandom;
      else if (flavour < 9) val = base + $urandom_range(4095);
      else                  val = base;
      queue_sample(val, i == len - 1);
    end
  endtask

  task automatic random_phase(int total);
    int sent;
    int len;
    sent = 0;
    while (sent < total) begin
      len = $urandom_range(8, 1);
      queue_random_set(len);
      sent += len;
    end
  endtask

  // Stimulus sequence.
  initial begin
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    failed      = 1'b0;
    send_idle_pct = 30;
    bins_reg = shm_pkg::BinsRst;
    clear_set_state();
    @(posedge rst_ni);

    // Reset bin count with the field extremes in one set.
    queue_sample(32'h8000_0000, 1'b0);
    queue_sample(32'h7FFF_FFFF, 1'b1);
    // A single-sample set.
    queue_sample(32'h0001_8000, 1'b1);
    // A bin count below the minimum is used as two.
    write_bins(6'd0);
    queue_sample(32'hFFFF_0000, 1'b0);
    queue_sample(32'h0002_0000, 1'b1);
    write_bins(6'd1);
    queue_sample(32'h0000_0001, 1'b0);
    queue_sample(32'h0000_0000, 1'b1);
    // All samples equal: zero, positive and negative values; then a set with the field extremes.
    write_bins(6'd63);
    repeat (3) queue_sample(32'h0000_0000, 1'b0);
    queue_sample(32'h0000_0000, 1'b1);
    repeat (2) queue_sample(32'h0005_0000, 1'b0);
    queue_sample(32'h0005_0000, 1'b1);
    queue_sample(32'hFFFD_0000, 1'b0);
    queue_sample(32'hFFFD_0000, 1'b1);
    queue_sample(32'h8000_0000, 1'b0);
    queue_sample(32'h7FFF_FFFF, 1'b0);
    queue_sample(32'h1234_5678, 1'b1);

    // Random sets, with the sender's idling varied between phases.
    write_bins(6'd5);
    send_idle_pct = 30;
    random_phase(30);
    write_bins(6'($urandom_range(63, 2)));
    send_idle_pct = 78;
    random_phase(28);
    write_bins(6'd63);
    send_idle_pct = 0;
    random_phase(28);
    write_bins(6'd2);
    random_phase(10);

    while (pending_samples.size() > 0 || start_i || expected_records.size() > 0)
      @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (!failed && expected_records.size() == 0)
      $display("[sample_histogram_with_moments] OK");
    else
      $display("[sample_histogram_with_moments] ERROR");
    $finish;
  end

endmodule
